[hw/rtl/pli_pkg.sv]
`default_nettype none

package pli_pkg;

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_READ   = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [5:0]         pos;
      logic signed [15:0] x_in;
      logic signed [15:0] y_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] x_out;
      logic signed [15:0] y_out;
      logic [6:0]         count;
   } rsp_type;

   typedef struct packed {
      logic ins;
      logic del;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/pli_cell.sv]
`default_nettype none

module pli_cell #(
   parameter int INDEX      = 0,
   parameter int CNT_W      = 7,
   parameter int COORD_BITS = 16
) (
   input  wire                          clock,
   input  pli_pkg::cell_ctrl_type       ctrl,
   input  wire  [CNT_W-1:0]             lo,
   input  wire  [CNT_W-1:0]             hi,
   input  wire  [2*COORD_BITS-1:0]      new_point,
   input  wire  [2*COORD_BITS-1:0]      left,
   input  wire  [2*COORD_BITS-1:0]      right,
   output logic [2*COORD_BITS-1:0]      q
);
   import pli_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] NXT = CNT_W'(INDEX + 1);

   logic [2*COORD_BITS-1:0] q_ff;
   logic [2*COORD_BITS-1:0] q_in;

   always_comb begin
      q_in = q_ff;
      if (ctrl.ins) begin
         if (IDX == lo) begin
            q_in = new_point;
         end else if ((IDX > lo) && (IDX <= hi)) begin
            q_in = left;
         end
      end
      if (ctrl.del) begin
         if ((IDX >= lo) && (NXT < hi)) begin
            q_in = right;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

`default_nettype wire

[hw/rtl/point_list_insert_remove_top.sv]
// point list with insert and remove by shifting
//
// request channel (req_valid/req_ready/req_data) carries one command:
// append, insert at pos, remove at pos, read at pos or clear. every
// request gives exactly one response on rsp_valid/rsp_ready/rsp_data
// with status, the point read (zero unless a read succeeded) and the
// count held after the command.
//
// each list entry lives in its own cell of a row; an insert moves every
// cell from pos upward by one toward the end and a remove moves the later
// cells down by one, all in the same cycle.
// the response appears in the cycle after the request is taken; one
// request per cycle is sustained while the receiver keeps rsp_ready high.
//
// reset empties the list (count zero) and drops any pending response;
// entry contents are not cleared. while a response waits for rsp_ready,
// req_ready is low unless that response is taken in the same cycle.
`default_nettype none

module point_list_insert_remove_top #(
   parameter int DEPTH      = 64,
   parameter int COORD_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  pli_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output pli_pkg::rsp_type  rsp_data
);
   import pli_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
   localparam int PT_W  = 2 * COORD_BITS;

   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             accept;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] fill_ext;
   logic             full;
   cell_ctrl_type    ctrl;
   logic [CNT_W-1:0] lo;
   logic [PT_W-1:0]  new_point;
   logic [PT_W-1:0]  cell_q [DEPTH];
   logic [PT_W-1:0]  rd_point;
   logic [31:0]      x_ext;
   logic [31:0]      y_ext;
   logic [31:0]      xin_zext;
   logic [31:0]      yin_zext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pos_ext   = CMP_W'(req_data.pos);
   assign fill_ext  = CMP_W'(fill_ff);
   assign full      = (fill_ff == CNT_W'(DEPTH));

   assign xin_zext  = 32'({16'd0, req_data.x_in});
   assign yin_zext  = 32'({16'd0, req_data.y_in});
   assign new_point = {xin_zext[COORD_BITS-1:0], yin_zext[COORD_BITS-1:0]};

   assign rd_point  = cell_q[pos_ext[IDX_W-1:0]];
   assign x_ext     = 32'(signed'(rd_point[PT_W-1:COORD_BITS]));
   assign y_ext     = 32'(signed'(rd_point[COORD_BITS-1:0]));

   always_comb begin
      ctrl             = '0;
      lo               = pos_ext[CNT_W-1:0];
      fill_in          = fill_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = ST_DONE;
         rsp_in.x_out  = '0;
         rsp_in.y_out  = '0;
         case (req_data.cmd)
            CMD_APPEND: begin
               if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  lo       = fill_ff;
                  fill_in  = fill_ff + 1'b1;
               end
            end
            CMD_INSERT: begin
               if (full) begin
                  rsp_in.status = ST_FULL;
               end else if (pos_ext > fill_ext) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  ctrl.ins = 1'b1;
                  fill_in  = fill_ff + 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (pos_ext >= fill_ext) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  ctrl.del = 1'b1;
                  fill_in  = fill_ff - 1'b1;
               end
            end
            CMD_READ: begin
               if (pos_ext >= fill_ext) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  rsp_in.x_out = x_ext[15:0];
                  rsp_in.y_out = y_ext[15:0];
               end
            end
            CMD_CLEAR: begin
               fill_in = '0;
            end
            default: begin
            end
         endcase
         rsp_in.count = 7'(fill_in);
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [PT_W-1:0] left;
      logic [PT_W-1:0] right;
      if (i == 0) begin : g_first
         assign left = '0;
      end else begin : g_mid
         assign left = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right = '0;
      end else begin : g_inner
         assign right = cell_q[i+1];
      end
      pli_cell #(
         .INDEX      (i),
         .CNT_W      (CNT_W),
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .lo        (lo),
         .hi        (fill_ff),
         .new_point (new_point),
         .left      (left),
         .right     (right),
         .q         (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/pli_checker.sv]
`default_nettype none

module pli_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input pli_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input pli_pkg::rsp_type rsp_data
);
   import pli_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_no_take_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response blocked");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.cmd == CMD_CLEAR)
      |=> rsp_valid && (rsp_data.count == 7'd0) && (rsp_data.status == ST_DONE))
      else $error("clear did not empty list");

   a_read_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.cmd == CMD_READ)
      |=> rsp_valid && ((rsp_data.status == ST_DONE) || (rsp_data.status == ST_RANGE)))
      else $error("bad read status");

endmodule

bind point_list_insert_remove_top pli_checker u_pli_checker (.*);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
   import pli_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int ITEMS_PER_PHASE = 430;

   // command codes that the block treats as no-ops
   localparam logic [2:0] CMD_SPARE5 = 3'd5;
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   localparam bit TYPED = 1'b1;
   localparam bit FREE  = 1'b0;

   typedef struct packed {
      req_type    q;
      logic       typed;
      rsp_type    want;
   } script_row_type;

   logic     clock;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_data = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_data;

   // list shadow
   logic signed [15:0] held_x [LIST_DEPTH];
   logic signed [15:0] held_y [LIST_DEPTH];
   int                 n_held = 0;

   rsp_type        owed_rsp_q [$];
   script_row_type script [$];

   int  req_idle_pct = 25;
   int  rsp_idle_pct = 77;
   bit  growing = 1'b1;
   int  n_errors = 0;
   int  n_requests = 0;
   int  n_full_rej = 0;
   int  n_range_rej = 0;
   int  n_read_ok = 0;
   int  n_full_hits = 0;

   point_list_insert_remove_top #(
      .DEPTH      (LIST_DEPTH),
      .COORD_BITS (16)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("point_list_insert_remove_top regression: fail");
      $finish;
   end

   task automatic flag_error(input string msg);
      n_errors++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic rsp_type apply_list_cmd(input req_type r);
      rsp_type o;
      int      i;
      o = '0;
      o.status = ST_DONE;
      case (r.cmd)
         CMD_APPEND: begin
            if (n_held >= LIST_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               held_x[n_held] = r.x_in;
               held_y[n_held] = r.y_in;
               n_held++;
            end
         end
         CMD_INSERT: begin
            if (n_held >= LIST_DEPTH) begin
               o.status = ST_FULL;
            end else if (int'(r.pos) > n_held) begin
               o.status = ST_RANGE;
            end else begin
               for (i = n_held; i > int'(r.pos); i--) begin
                  held_x[i] = held_x[i - 1];
                  held_y[i] = held_y[i - 1];
               end
               held_x[r.pos] = r.x_in;
               held_y[r.pos] = r.y_in;
               n_held++;
            end
         end
         CMD_REMOVE: begin
            if (int'(r.pos) >= n_held) begin
               o.status = ST_RANGE;
            end else begin
               for (i = int'(r.pos); i + 1 < n_held; i++) begin
                  held_x[i] = held_x[i + 1];
                  held_y[i] = held_y[i + 1];
               end
               n_held--;
            end
         end
         CMD_READ: begin
            if (int'(r.pos) >= n_held) begin
               o.status = ST_RANGE;
            end else begin
               o.x_out = held_x[r.pos];
               o.y_out = held_y[r.pos];
            end
         end
         CMD_CLEAR: begin
            n_held = 0;
         end
         default: begin
         end
      endcase
      o.count = 7'(n_held);
      return o;
   endfunction

   task automatic send_cmd(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      int      was_held;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      was_held = n_held;
      predicted = apply_list_cmd(r);
      owed_rsp_q.insert(owed_rsp_q.size(), typed ? want : predicted);
      n_requests++;
      if (predicted.status == ST_FULL) n_full_rej++;
      if (predicted.status == ST_RANGE) n_range_rej++;
      if (r.cmd == CMD_READ && predicted.status == ST_DONE) n_read_ok++;
      if (n_held == LIST_DEPTH && was_held < LIST_DEPTH) n_full_hits++;
   endtask

   task automatic drain_owed();
      req_valid <= 1'b0;
      while (owed_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input logic [2:0] c, input int p, input int x, input int y,
                          input bit typed, input logic [1:0] st, input int cnt);
      script_row_type row;
      row = '0;
      row.q.cmd  = c;
      row.q.pos  = 6'(p);
      row.q.x_in = 16'(x);
      row.q.y_in = 16'(y);
      row.typed  = typed;
      row.want.status = st;
      row.want.count  = 7'(cnt);
      script.insert(script.size(), row);
   endtask

   task automatic run_random_phase(input int n_items);
      req_type r;
      int      k;
      int      roll;
      int      top;
      for (k = 0; k < n_items; k++) begin
         if (n_held == LIST_DEPTH && $urandom_range(99) < 30) begin
            growing = 1'b0;
         end else if (n_held == 0 || (!growing && $urandom_range(99) < 2)) begin
            growing = 1'b1;
         end
         roll   = $urandom_range(99);
         r.x_in = 16'($urandom);
         r.y_in = 16'($urandom);
         r.pos  = 6'($urandom);
         if (roll >= 95) begin
            r.cmd = 3'($urandom_range(7, 5));
         end else if (roll == 94) begin
            r.cmd = ($urandom_range(3) == 0 || !growing) ? CMD_CLEAR : CMD_READ;
         end else if (growing) begin
            if (roll < 40) r.cmd = CMD_APPEND;
            else if (roll < 80) r.cmd = CMD_INSERT;
            else if (roll < 88) r.cmd = CMD_READ;
            else r.cmd = CMD_REMOVE;
         end else begin
            if (roll < 55) r.cmd = CMD_REMOVE;
            else if (roll < 80) r.cmd = CMD_READ;
            else if (roll < 87) r.cmd = CMD_APPEND;
            else r.cmd = CMD_INSERT;
         end
         // mostly aim inside the list
         if ($urandom_range(99) < 85) begin
            if (r.cmd == CMD_INSERT) begin
               top = (n_held > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : n_held;
               r.pos = 6'($urandom_range(top));
            end else if (n_held > 0) begin
               r.pos = 6'($urandom_range(n_held - 1));
            end
         end
         send_cmd(r, FREE, '0);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_rsp_q.size() == 0) begin
            flag_error("response with no request outstanding");
         end else begin
            want = owed_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               flag_error($sformatf("status got %0d want %0d", rsp_data.status, want.status));
            if (rsp_data.x_out !== want.x_out)
               flag_error($sformatf("x_out got %0d want %0d", rsp_data.x_out, want.x_out));
            if (rsp_data.y_out !== want.y_out)
               flag_error($sformatf("y_out got %0d want %0d", rsp_data.y_out, want.y_out));
            if (rsp_data.count !== want.count)
               flag_error($sformatf("count got %0d want %0d", rsp_data.count, want.count));
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      int i;
      // empty list
      add_row(CMD_READ,   0,      0,      0,  TYPED, ST_RANGE, 0);
      add_row(CMD_REMOVE, 0,      0,      0,  TYPED, ST_RANGE, 0);
      add_row(CMD_INSERT, 1,      5,      5,  TYPED, ST_RANGE, 0);
      add_row(CMD_SPARE5, 63, -1,     -1,     TYPED, ST_DONE,  0);
      // build up with extreme coordinates, insert at the count acts as append
      add_row(CMD_INSERT, 0, -32768,  32767,  TYPED, ST_DONE,  1);
      add_row(CMD_APPEND, 63, 32767, -32768,  TYPED, ST_DONE,  2);
      add_row(CMD_INSERT, 2,      0,     -1,  TYPED, ST_DONE,  3);
      add_row(CMD_INSERT, 1,     -1,      0,  TYPED, ST_DONE,  4);
      add_row(CMD_READ,   0,      0,      0,  FREE,  ST_DONE,  0);
      add_row(CMD_READ,   1,      0,      0,  FREE,  ST_DONE,  0);
      add_row(CMD_READ,   2,      0,      0,  FREE,  ST_DONE,  0);
      add_row(CMD_READ,   3,      0,      0,  FREE,  ST_DONE,  0);
      add_row(CMD_READ,   4,      0,      0,  TYPED, ST_RANGE, 4);
      add_row(CMD_INSERT, 63,     7,      7,  TYPED, ST_RANGE, 4);
      add_row(CMD_REMOVE, 63,     0,      0,  TYPED, ST_RANGE, 4);
      // remove from the middle and from the end
      add_row(CMD_REMOVE, 1,      0,      0,  TYPED, ST_DONE,  3);
      add_row(CMD_READ,   1,      0,      0,  FREE,  ST_DONE,  0);
      add_row(CMD_REMOVE, 2,      0,      0,  TYPED, ST_DONE,  2);
      add_row(CMD_SPARE6, 63, 32767,  32767,  TYPED, ST_DONE,  2);
      add_row(CMD_SPARE7, 0, -32768, -32768,  TYPED, ST_DONE,  2);
      add_row(CMD_CLEAR,  17,     3,      3,  TYPED, ST_DONE,  0);
      add_row(CMD_READ,   0,      0,      0,  TYPED, ST_RANGE, 0);
      add_row(CMD_APPEND, 0,   4660,  -4660,  TYPED, ST_DONE,  1);
      add_row(CMD_READ,   0,      0,      0,  FREE,  ST_DONE,  0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 25;
      rsp_idle_pct = 77;
      for (i = 0; i < script.size(); i++) begin
         send_cmd(script[i].q, script[i].typed, script[i].want);
      end
      run_random_phase(ITEMS_PER_PHASE);
      drain_owed();

      req_idle_pct = 77;
      rsp_idle_pct = 25;
      run_random_phase(ITEMS_PER_PHASE);
      drain_owed();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random_phase(ITEMS_PER_PHASE);
      drain_owed();
      repeat (4) @(posedge clock);

      $display("covered %0d requests: %0d good reads, list filled to capacity %0d times",
               n_requests, n_read_ok, n_full_hits);
      $display("rejections seen: %0d list full, %0d position out of range",
               n_full_rej, n_range_rej);
      if (n_errors == 0) begin
         $display("point_list_insert_remove_top regression: pass");
      end else begin
         $display("point_list_insert_remove_top regression: fail");
      end
      $finish;
   end

endmodule
